/* sv/tga_rle_pkg.sv */
package tga_rle_pkg;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PIXEL  = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] width;
		logic [15:0] height;
		logic        has_alpha;
		logic [31:0] pixel_value;
		logic [7:0]  repeat_count;
		logic        image_done;
	} result_t;

endpackage

/* sv/tga_rle_front.sv */
module tga_rle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          data_byte,
	input  logic                file_start,
	output logic                push,
	output tga_rle_pkg::result_t push_data
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_IDSKIP = 3'd1;
	localparam logic [2:0] PH_PACKET = 3'd2;
	localparam logic [2:0] PH_PIXEL  = 3'd3;
	localparam logic [2:0] PH_IDLE   = 3'd4;

	localparam logic [7:0] TYPE_RAW   = 8'd2;
	localparam logic [7:0] TYPE_RLE   = 8'd10;
	localparam logic [7:0] DEPTH_BGR  = 8'd24;
	localparam logic [7:0] DEPTH_BGRA = 8'd32;

	logic [2:0]  phase_q, phase_d, cur_phase;
	logic [4:0]  hidx_q, hidx_d, cur_hidx;
	logic [7:0]  id_skip_q, id_skip_d;
	logic        compressed_q, compressed_d;
	logic        four_q, four_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [31:0] pixels_left_q, pixels_left_d;
	logic [7:0]  packet_left_q, packet_left_d;
	logic        run_q, run_d;
	logic [31:0] accum_q, accum_d;
	logic [1:0]  bip_q, bip_d;

	logic        start;
	logic        empty_image;
	logic [31:0] area;
	logic [31:0] acc_new;
	logic        pixel_complete;
	logic [7:0]  count;
	logic [7:0]  packet_left_next;
	logic        last_pixel;

	assign area = {16'd0, width_q} * {16'd0, height_q};
	assign empty_image = (width_q == 16'd0) || (height_q == 16'd0);
	assign acc_new = accum_q | ({24'd0, data_byte} << {bip_q, 3'b000});
	assign pixel_complete = (bip_q == 2'd3) || (!four_q && bip_q == 2'd2);

	always_comb begin
		cur_phase = file_start ? PH_HEADER : phase_q;
		cur_hidx = file_start ? 5'd0 : hidx_q;

		phase_d = cur_phase;
		hidx_d = cur_hidx;
		id_skip_d = id_skip_q;
		compressed_d = compressed_q;
		four_d = four_q;
		width_d = width_q;
		height_d = height_q;
		pixels_left_d = pixels_left_q;
		packet_left_d = packet_left_q;
		run_d = run_q;
		accum_d = accum_q;
		bip_d = bip_q;

		start = 1'b0;
		push = 1'b0;
		count = 8'd1;
		packet_left_next = packet_left_q;
		last_pixel = 1'b0;

		push_data.kind = tga_rle_pkg::KIND_PIXEL;
		push_data.width = width_q;
		push_data.height = height_q;
		push_data.has_alpha = four_q;
		push_data.pixel_value = 32'd0;
		push_data.repeat_count = 8'd0;
		push_data.image_done = 1'b0;

		if (take) begin
			unique case (cur_phase)
				PH_HEADER: begin
					hidx_d = cur_hidx + 5'd1;
					case (cur_hidx)
						5'd0: id_skip_d = data_byte;
						5'd2: begin
							if (data_byte != TYPE_RAW && data_byte != TYPE_RLE) begin
								phase_d = PH_IDLE;
								push = 1'b1;
								push_data.kind = tga_rle_pkg::KIND_ERROR;
							end else begin
								compressed_d = (data_byte == TYPE_RLE);
							end
						end
						5'd12: width_d = {width_q[15:8], data_byte};
						5'd13: width_d = {data_byte, width_q[7:0]};
						5'd14: height_d = {height_q[15:8], data_byte};
						5'd15: height_d = {data_byte, height_q[7:0]};
						5'd16: begin
							if (data_byte != DEPTH_BGR && data_byte != DEPTH_BGRA) begin
								phase_d = PH_IDLE;
								push = 1'b1;
								push_data.kind = tga_rle_pkg::KIND_ERROR;
							end else begin
								four_d = (data_byte == DEPTH_BGRA);
							end
						end
						5'd17: begin
							if (id_skip_q != 8'd0)
								phase_d = PH_IDSKIP;
							else
								start = 1'b1;
						end
						default: ;
					endcase
				end
				PH_IDSKIP: begin
					id_skip_d = id_skip_q - 8'd1;
					if (id_skip_q == 8'd1)
						start = 1'b1;
				end
				PH_PACKET: begin
					// low seven bits hold count minus one for both packet types
					run_d = data_byte[7];
					packet_left_d = {1'b0, data_byte[6:0]} + 8'd1;
					accum_d = 32'd0;
					bip_d = 2'd0;
					phase_d = PH_PIXEL;
				end
				PH_PIXEL: begin
					if (pixel_complete) begin
						if (run_q) begin
							// clip the run to what is left of the image
							if (pixels_left_q < {24'd0, packet_left_q})
								count = pixels_left_q[7:0];
							else
								count = packet_left_q;
							packet_left_next = 8'd0;
							run_d = 1'b0;
						end else begin
							count = 8'd1;
							if (packet_left_q != 8'd0)
								packet_left_next = packet_left_q - 8'd1;
						end
						last_pixel = (pixels_left_q == {24'd0, count});
						packet_left_d = packet_left_next;
						pixels_left_d = pixels_left_q - {24'd0, count};
						accum_d = 32'd0;
						bip_d = 2'd0;
						if (last_pixel)
							phase_d = PH_IDLE;
						else if (compressed_q && packet_left_next == 8'd0)
							phase_d = PH_PACKET;
						else
							phase_d = PH_PIXEL;
						push = 1'b1;
						push_data.pixel_value = acc_new;
						push_data.repeat_count = count;
						push_data.image_done = last_pixel;
					end else begin
						accum_d = acc_new;
						bip_d = bip_q + 2'd1;
					end
				end
				PH_IDLE: ;
				default: ;
			endcase

			if (start) begin
				pixels_left_d = area;
				accum_d = 32'd0;
				bip_d = 2'd0;
				packet_left_d = 8'd0;
				run_d = 1'b0;
				if (empty_image)
					phase_d = PH_IDLE;
				else if (compressed_q)
					phase_d = PH_PACKET;
				else
					phase_d = PH_PIXEL;
				push = 1'b1;
				push_data.kind = tga_rle_pkg::KIND_HEADER;
				push_data.image_done = empty_image;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hidx_q <= 5'd0;
			id_skip_q <= 8'd0;
			compressed_q <= 1'b0;
			four_q <= 1'b0;
			width_q <= 16'd0;
			height_q <= 16'd0;
			pixels_left_q <= 32'd0;
			packet_left_q <= 8'd0;
			run_q <= 1'b0;
			accum_q <= 32'd0;
			bip_q <= 2'd0;
		end else if (take) begin
			phase_q <= phase_d;
			hidx_q <= hidx_d;
			id_skip_q <= id_skip_d;
			compressed_q <= compressed_d;
			four_q <= four_d;
			width_q <= width_d;
			height_q <= height_d;
			pixels_left_q <= pixels_left_d;
			packet_left_q <= packet_left_d;
			run_q <= run_d;
			accum_q <= accum_d;
			bip_q <= bip_d;
		end
	end

endmodule

/* sv/tga_rle_queue.sv */
module tga_rle_queue #(
	parameter int Depth = tga_rle_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tga_rle_pkg::result_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output tga_rle_pkg::result_t head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	tga_rle_pkg::result_t entries_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full = (count_q == FullCnt);
	assign head_valid = (count_q != '0);
	assign head = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* sv/tga_rle_back.sv */
module tga_rle_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  tga_rle_pkg::result_t head,
	output logic                 pop,
	output logic                 result_valid,
	input  logic                 result_stall,
	output tga_rle_pkg::result_t result
);

	logic                 valid_q;
	logic                 load;
	tga_rle_pkg::result_t shaped;
	tga_rle_pkg::result_t result_q;

	assign load = !valid_q || !result_stall;
	assign pop = load && head_valid;

	// error beats carry nothing but their kind
	always_comb begin
		shaped = head;
		if (head.kind == tga_rle_pkg::KIND_ERROR) begin
			shaped.width = 16'd0;
			shaped.height = 16'd0;
			shaped.has_alpha = 1'b0;
			shaped.pixel_value = 32'd0;
			shaped.repeat_count = 8'd0;
			shaped.image_done = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop)
			result_q <= shaped;
	end

	assign result_valid = valid_q;
	assign result = result_q;

endmodule

/* sv/tga_rle_image_decoder.sv */
// channel  direction  handshake                   payload
// byte     in         byte_valid / byte_stall     data_byte, file_start
// result   out        result_valid / result_stall kind, width, height, has_alpha,
//                                                 pixel_value, repeat_count, image_done
//
// one file byte per cycle while byte_stall is low; the parser finishes each byte in the cycle it is taken
// a result beat reaches the outputs via a small queue and the output register;
// pixels_left comes from one 16x16 multiply
// byte_stall rises only while the queue is full, i.e. after the result side has stalled
// arst_n clears parser state, queue pointers and the output valid
module tga_rle_image_decoder #(
	parameter int QueueDepth = tga_rle_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [15:0] width,
	output logic [15:0] height,
	output logic        has_alpha,
	output logic [31:0] pixel_value,
	output logic [7:0]  repeat_count,
	output logic        image_done
);

	logic                 take;
	logic                 push;
	tga_rle_pkg::result_t push_data;
	logic                 full;
	logic                 pop;
	logic                 head_valid;
	tga_rle_pkg::result_t head;
	tga_rle_pkg::result_t result;

	assign byte_stall = full;
	assign take = byte_valid && !full;

	tga_rle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.file_start(file_start),
		.push      (push),
		.push_data (push_data)
	);

	tga_rle_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	tga_rle_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	assign kind = result.kind;
	assign width = result.width;
	assign height = result.height;
	assign has_alpha = result.has_alpha;
	assign pixel_value = result.pixel_value;
	assign repeat_count = result.repeat_count;
	assign image_done = result.image_done;

endmodule
